// ===== hdl/ddsp_pkg.sv =====
package ddsp_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_NODES   = 8;
    localparam int DEF_WEIGHT_BITS = 16;

    // Results of one run never exceed this many vertices
    localparam int RESULT_LIMIT = 8;

    // Fixed field widths
    localparam int NODE_CNT_W  = 4;
    localparam int VERTEX_W    = 3;
    localparam int IN_WEIGHT_W = 16;
    localparam int PATH_W      = 32;

    localparam logic [NODE_CNT_W-1:0] NODE_CNT_RESET = NODE_CNT_W'(8);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_RUN  = 1'b1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_RELAX = 6'b001000,
        S_OUT   = 6'b010000,
        S_SPARE = 6'b100000
    } t_state;

endpackage

// ===== hdl/dense_dijkstra_shortest_paths_core.sv =====
// Load item: accepted while idle, busy stays low. Run item over n vertices: the accept cycle, then
// up to n rounds of a minimum scan over the n vertices and a relax pass through the
// registered weight-store read port, then one result per vertex.
// After reset the weight store is cleared one entry a cycle, all MAX_NODES*MAX_NODES
// entries, with busy high; results strobe for one cycle each, the receiver cannot stall.
module dense_dijkstra_shortest_paths_core #(
    parameter int MAX_NODES   = ddsp_pkg::DEF_MAX_NODES,
    parameter int WEIGHT_BITS = ddsp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [ddsp_pkg::NODE_CNT_W-1:0]    i_cfg_wr_data,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_action,
    input  logic [ddsp_pkg::VERTEX_W-1:0]      i_from_vertex,
    input  logic [ddsp_pkg::VERTEX_W-1:0]      i_to_vertex,
    input  logic [ddsp_pkg::IN_WEIGHT_W-1:0]   i_edge_weight,
    input  logic [ddsp_pkg::VERTEX_W-1:0]      i_source_vertex,
    output logic                               o_valid,
    output logic [ddsp_pkg::VERTEX_W-1:0]      o_vertex_index,
    output logic                               o_reachable,
    output logic [ddsp_pkg::PATH_W-1:0]        o_path_length,
    output logic                               o_last_vertex
);

    localparam int LIMIT  = (MAX_NODES < ddsp_pkg::RESULT_LIMIT) ? MAX_NODES
                                                                  : ddsp_pkg::RESULT_LIMIT;
    localparam int VI_W   = $clog2(LIMIT);
    localparam int CNT_W  = $clog2(LIMIT + 1);
    localparam int DEPTH  = MAX_NODES * MAX_NODES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PW     = ddsp_pkg::PATH_W;

    ddsp_pkg::t_state r_state;

    logic [ddsp_pkg::NODE_CNT_W-1:0] r_node_count;
    logic [CNT_W-1:0]                r_n;
    logic [CNT_W-1:0]                r_k;
    logic [CNT_W-1:0]                r_round;
    logic [VI_W-1:0]                 r_m;
    logic [PW-1:0]                   r_best;
    logic                            r_found;
    logic [LIMIT-1:0]                r_reach;
    logic [LIMIT-1:0]                r_visited;
    logic [PW-1:0]                   r_dist [LIMIT];
    logic                            r_pv;
    logic [VI_W-1:0]                 r_pk;
    logic [ADDR_W-1:0]               r_clr;

    logic [WEIGHT_BITS-1:0]          r_mem [DEPTH];
    logic [WEIGHT_BITS-1:0]          r_wrd;

    logic                            is_idle;
    logic                            accept;
    logic                            load_wr;
    logic [ADDR_W-1:0]               waddr;
    logic [ADDR_W-1:0]               raddr;
    logic [ddsp_pkg::NODE_CNT_W-1:0] n_count;
    logic [VI_W-1:0]                 k_idx;
    logic                            k_last;
    logic                            take;
    logic                            found_any;
    logic [VI_W-1:0]                 pick_m;
    logic [PW-1:0]                   pick_best;
    logic [PW:0]                     sum;
    logic [PW-1:0]                   cand;
    logic                            relax_upd;

    assign is_idle = (r_state == ddsp_pkg::S_IDLE);
    assign busy    = !is_idle;
    assign accept  = start && is_idle;

    // Vertices in use, clipped to what the store and result limit allow
    assign n_count = (r_node_count > ddsp_pkg::NODE_CNT_W'(LIMIT))
                   ? ddsp_pkg::NODE_CNT_W'(LIMIT) : r_node_count;

    assign load_wr = accept && (i_action == ddsp_pkg::ACT_LOAD)
                     && (32'(i_from_vertex) < MAX_NODES) && (32'(i_to_vertex) < MAX_NODES);
    assign waddr   = ADDR_W'(ADDR_W'(i_from_vertex) * ADDR_W'(MAX_NODES))
                   + ADDR_W'(i_to_vertex);

    assign k_idx  = r_k[VI_W-1:0];
    assign k_last = (r_k == r_n - CNT_W'(1));
    assign raddr  = ADDR_W'(ADDR_W'(r_m) * ADDR_W'(MAX_NODES)) + ADDR_W'(k_idx);

    // Minimum scan: highest index wins on ties
    always_comb begin
        take      = !r_visited[k_idx] && r_reach[k_idx]
                    && (!r_found || (r_dist[k_idx] <= r_best));
        found_any = r_found || take;
        pick_m    = take ? k_idx : r_m;
        pick_best = take ? r_dist[k_idx] : r_best;
    end

    // Relax stage on the registered weight read
    always_comb begin
        sum       = {1'b0, r_best} + (PW+1)'(r_wrd);
        cand      = sum[PW] ? {PW{1'b1}} : sum[PW-1:0];
        relax_upd = r_pv && !r_visited[r_pk] && (r_wrd != '0)
                    && (!r_reach[r_pk] || (cand < r_dist[r_pk]));
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ddsp_pkg::S_CLEAR) begin
            r_mem[r_clr] <= '0;
        end else if (load_wr) begin
            r_mem[waddr] <= WEIGHT_BITS'(i_edge_weight);
        end
        r_wrd <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= ddsp_pkg::NODE_CNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_node_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (relax_upd) begin
            r_dist[r_pk] <= cand;
        end else if (accept && (i_action == ddsp_pkg::ACT_RUN)) begin
            r_dist[i_source_vertex[VI_W-1:0]] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ddsp_pkg::S_CLEAR;
            r_clr     <= '0;
            r_n       <= '0;
            r_k       <= '0;
            r_round   <= '0;
            r_m       <= '0;
            r_best    <= '0;
            r_found   <= 1'b0;
            r_reach   <= '0;
            r_visited <= '0;
            r_pv      <= 1'b0;
            r_pk      <= '0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            r_pv    <= 1'b0;
            unique case (r_state)
                ddsp_pkg::S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= ddsp_pkg::S_IDLE;
                    end
                end
                ddsp_pkg::S_IDLE: begin
                    if (accept && (i_action == ddsp_pkg::ACT_RUN)) begin
                        r_n       <= CNT_W'(n_count);
                        r_k       <= '0;
                        r_round   <= '0;
                        r_found   <= 1'b0;
                        r_visited <= '0;
                        r_reach   <= '0;
                        if (n_count == '0) begin
                            r_state <= ddsp_pkg::S_IDLE;
                        end else if (ddsp_pkg::NODE_CNT_W'(i_source_vertex) >= n_count) begin
                            r_state <= ddsp_pkg::S_OUT;
                        end else begin
                            r_reach[i_source_vertex[VI_W-1:0]] <= 1'b1;
                            r_state <= ddsp_pkg::S_SCAN;
                        end
                    end
                end
                ddsp_pkg::S_SCAN: begin
                    r_found <= found_any;
                    r_m     <= pick_m;
                    r_best  <= pick_best;
                    if (k_last) begin
                        r_k <= '0;
                        if (found_any) begin
                            r_visited[pick_m] <= 1'b1;
                            r_state           <= ddsp_pkg::S_RELAX;
                        end else begin
                            // nothing reachable is left: remaining rounds do nothing
                            r_state <= ddsp_pkg::S_OUT;
                        end
                    end else begin
                        r_k <= r_k + CNT_W'(1);
                    end
                end
                ddsp_pkg::S_RELAX: begin
                    if (relax_upd) begin
                        r_reach[r_pk] <= 1'b1;
                    end
                    if (r_k != r_n) begin
                        r_pv <= 1'b1;
                        r_pk <= k_idx;
                        r_k  <= r_k + CNT_W'(1);
                    end else if (!r_pv) begin
                        r_k     <= '0;
                        r_found <= 1'b0;
                        r_round <= r_round + CNT_W'(1);
                        if (r_round + CNT_W'(1) == r_n) begin
                            r_state <= ddsp_pkg::S_OUT;
                        end else begin
                            r_state <= ddsp_pkg::S_SCAN;
                        end
                    end
                end
                ddsp_pkg::S_OUT: begin
                    o_valid <= 1'b1;
                    if (k_last) begin
                        r_k     <= '0;
                        r_state <= ddsp_pkg::S_IDLE;
                    end else begin
                        r_k <= r_k + CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= ddsp_pkg::S_IDLE;
                end
            endcase
        end
    end

    // Result payload: hold between strobes
    always_ff @(posedge i_clk) begin
        if (r_state == ddsp_pkg::S_OUT) begin
            o_vertex_index <= ddsp_pkg::VERTEX_W'(r_k);
            o_reachable    <= r_reach[k_idx];
            o_path_length  <= r_reach[k_idx] ? r_dist[k_idx] : '0;
            o_last_vertex  <= k_last;
        end
    end

endmodule
